// ----- design/bsc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsc_pkg
// Types and constants shared by the barometer compensation block.
// ----------------------------------------------------------------------------
package bsc_pkg;

    typedef enum logic [4:0] {
        S_IDLE,
        S_T0,
        S_T1,
        S_T2,
        S_P0,
        S_P1,
        S_P2,
        S_P3,
        S_P4,
        S_P5,
        S_P6,
        S_P7,
        S_DIV,
        S_Q0,
        S_Q1,
        S_Q2,
        S_Q3,
        S_OUT
    } t_state;

    typedef enum logic [1:0] {
        REG_OSS   = 2'd0,
        REG_CAL_A = 2'd1,
        REG_CAL_B = 2'd2,
        REG_CAL_C = 2'd3
    } t_reg_idx;

    localparam logic       FUNC_TEMP  = 1'b0;
    localparam logic       FUNC_PRESS = 1'b1;

    localparam logic [31:0] C_B6_OFS   = 32'd4000;
    localparam logic [31:0] C_P_K1     = 32'd3038;
    localparam logic [31:0] C_P_K2     = 32'hFFFF_E343; // -7357
    localparam logic [31:0] C_P_K3     = 32'd3791;
    localparam logic [31:0] C_B7_SCALE = 32'd50000;
    localparam logic [31:0] C_B4_OFS   = 32'd32768;

endpackage

// ----- design/bsc_req_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsc_req_if
// Request channel: raw reading with valid/ready handshake.
// ----------------------------------------------------------------------------
interface bsc_req_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic [23:0] raw_data;

    modport source (output valid, func, raw_data, input ready);
    modport sink   (input valid, func, raw_data, output ready);
endinterface

// ----- design/bsc_res_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsc_res_if
// Result channel: compensated value with valid/ready handshake.
// ----------------------------------------------------------------------------
interface bsc_res_if;
    logic               valid;
    logic               ready;
    logic               result_kind;
    logic signed [31:0] result_value;
    logic               div_error;

    modport source (output valid, result_kind, result_value, div_error, input ready);
    modport sink   (input valid, result_kind, result_value, div_error, output ready);
endinterface

// ----- design/baro_sensor_compensation_top.sv -----
`timescale 1ns / 1ps
// a zero divisor ends a request early: the sequence skips the divider and goes straight to the result
// one request at a time: a new request is taken only once the result has been taken,
// as the 32-step serial divider and the single 32x32 multiplier are shared
// reset: synchronous active low; clears config registers, kept b5 term and control
// ----------------------------------------------------------------------------
// baro_sensor_compensation_top
// Temperature and pressure compensation using one shared multiplier and
// one restoring divider under a small sequencer.
// ----------------------------------------------------------------------------
module baro_sensor_compensation_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [63:0] i_cfg_wdata,
    bsc_req_if.sink     i_req,
    bsc_res_if.source   o_res
);
    import bsc_pkg::*;

    t_state r_state, n_state;

    logic [1:0]  r_oss;
    logic [63:0] r_cal_a, r_cal_b;
    logic [31:0] r_cal_c;
    logic [31:0] r_temp_term;

    logic        r_kind;
    logic [23:0] r_raw;
    logic [31:0] r_prod;
    logic [31:0] r_b6, r_sq, r_x1, r_b3, r_b4, r_up, r_y1, r_pv;
    logic [31:0] r_value;
    logic        r_err;

    logic [32:0] r_rem;
    logic [31:0] r_quo, r_dvs;
    logic [4:0]  r_cnt;
    logic        r_qneg, r_qshl;

    logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
    logic [31:0] mul_a, mul_b, n_prod;
    logic [31:0] ut, b6, sq, x3a, t0, t1, b3, x3b, den, num_t, b7;
    logic [31:0] q_fin, q_neg, y1, pq, xs;
    logic [32:0] shifted;
    logic        div_done;

    assign ac1 = {{16{r_cal_a[63]}}, r_cal_a[63:48]};
    assign ac2 = {{16{r_cal_a[47]}}, r_cal_a[47:32]};
    assign ac3 = {{16{r_cal_a[31]}}, r_cal_a[31:16]};
    assign ac4 = {16'd0, r_cal_a[15:0]};
    assign ac5 = {16'd0, r_cal_b[63:48]};
    assign ac6 = {16'd0, r_cal_b[47:32]};
    assign b1  = {{16{r_cal_b[31]}}, r_cal_b[31:16]};
    assign b2  = {{16{r_cal_b[15]}}, r_cal_b[15:0]};
    assign mc  = {{16{r_cal_c[31]}}, r_cal_c[31:16]};
    assign md  = {{16{r_cal_c[15]}}, r_cal_c[15:0]};

    // temperature path
    assign ut    = {16'd0, r_raw[15:0]};
    assign y1    = 32'($signed(r_prod) >>> 15);
    assign den   = y1 + md;
    assign num_t = {{5{mc[15]}}, mc[15:0], 11'd0};

    // pressure path
    assign b6  = r_temp_term - C_B6_OFS;
    assign sq  = 32'($signed(r_prod) >>> 12);
    assign x3a = r_x1 + 32'($signed(r_prod) >>> 11);
    assign t0  = ((ac1 << 2) + x3a) << r_oss;
    assign t1  = t0 + 32'd2;
    assign b3  = 32'($signed(t1 + (t1[31] ? 32'd3 : 32'd0)) >>> 2);
    assign xs  = r_x1 + 32'($signed(r_prod) >>> 16) + 32'd2;
    assign x3b = 32'($signed(xs) >>> 2);
    assign b7  = r_prod;

    // divider
    assign shifted  = {r_rem[31:0], r_quo[31]};
    assign div_done = (r_cnt == 5'd31);
    assign q_neg    = r_qneg ? (32'd0 - r_quo) : r_quo;
    assign q_fin    = r_qshl ? {q_neg[30:0], 1'b0} : q_neg;
    assign pq       = r_x1 + 32'($signed(r_prod) >>> 16) + C_P_K3;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_req.valid)
                    n_state = (i_req.func == FUNC_TEMP) ? S_T0 : S_P0;
            end
            S_T0: n_state = S_T1;
            S_T1: n_state = (den == 32'd0) ? S_OUT : S_DIV;
            S_T2: n_state = S_OUT;
            S_P0: n_state = S_P1;
            S_P1: n_state = S_P2;
            S_P2: n_state = S_P3;
            S_P3: n_state = S_P4;
            S_P4: n_state = S_P5;
            S_P5: n_state = S_P6;
            S_P6: n_state = S_P7;
            S_P7: n_state = (r_b4 == 32'd0) ? S_OUT : S_DIV;
            S_DIV: begin
                if (div_done)
                    n_state = (r_kind == FUNC_TEMP) ? S_T2 : S_Q0;
            end
            S_Q0: n_state = S_Q1;
            S_Q1: n_state = S_Q2;
            S_Q2: n_state = S_Q3;
            S_Q3: n_state = S_OUT;
            S_OUT: begin
                if (o_res.ready)
                    n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // multiplier operand select
    always_comb begin
        mul_a = 32'd0;
        mul_b = 32'd0;
        case (r_state)
            S_T0: begin mul_a = ut - ac6;           mul_b = ac5;   end
            S_P0: begin mul_a = b6;                 mul_b = b6;    end
            S_P1: begin mul_a = b2;                 mul_b = sq;    end
            S_P2: begin mul_a = ac2;                mul_b = r_b6;  end
            S_P3: begin mul_a = ac3;                mul_b = r_b6;  end
            S_P4: begin mul_a = b1;                 mul_b = r_sq;  end
            S_P5: begin mul_a = ac4;                mul_b = x3b + C_B4_OFS; end
            S_P6: begin mul_a = r_up - r_b3;        mul_b = C_B7_SCALE >> r_oss; end
            S_Q0: begin
                mul_a = 32'($signed(q_fin) >>> 8);
                mul_b = 32'($signed(q_fin) >>> 8);
            end
            S_Q1: begin mul_a = r_prod;             mul_b = C_P_K1; end
            S_Q2: begin mul_a = C_P_K2;             mul_b = r_pv;   end
            default: begin mul_a = 32'd0;           mul_b = 32'd0;  end
        endcase
    end

    assign n_prod = mul_a * mul_b;

    assign i_req.ready        = (r_state == S_IDLE);
    assign o_res.valid        = (r_state == S_OUT);
    assign o_res.result_kind  = r_kind;
    assign o_res.result_value = r_value;
    assign o_res.div_error    = r_err;

    // control and config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_oss       <= 2'd0;
            r_cal_a     <= 64'd0;
            r_cal_b     <= 64'd0;
            r_cal_c     <= 32'd0;
            r_temp_term <= 32'd0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (t_reg_idx'(i_cfg_idx))
                    REG_OSS:   r_oss   <= i_cfg_wdata[1:0];
                    REG_CAL_A: r_cal_a <= i_cfg_wdata;
                    REG_CAL_B: r_cal_b <= i_cfg_wdata;
                    REG_CAL_C: r_cal_c <= i_cfg_wdata[31:0];
                    default:   r_oss   <= r_oss;
                endcase
            end
            if (r_state == S_T2)
                r_temp_term <= r_y1 + q_fin;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
        case (r_state)
            S_IDLE: begin
                r_kind <= i_req.func;
                r_raw  <= i_req.raw_data;
                r_err  <= 1'b0;
            end
            S_T1: begin
                r_y1   <= y1;
                r_rem  <= 33'd0;
                r_cnt  <= 5'd0;
                r_quo  <= num_t[31] ? (32'd0 - num_t) : num_t;
                r_dvs  <= den[31] ? (32'd0 - den) : den;
                r_qneg <= num_t[31] ^ den[31];
                r_qshl <= 1'b0;
                if (den == 32'd0) begin
                    r_err   <= 1'b1;
                    r_value <= 32'd0;
                end
            end
            S_T2: r_value <= 32'($signed(r_y1 + q_fin + 32'd8) >>> 4);
            S_P0: begin
                r_b6 <= b6;
                r_up <= {8'd0, r_raw} >> (4'd8 - {2'd0, r_oss});
            end
            S_P1: r_sq <= sq;
            S_P2: r_x1 <= 32'($signed(r_prod) >>> 11);
            S_P3: r_b3 <= b3;
            S_P4: r_x1 <= 32'($signed(r_prod) >>> 13);
            S_P6: r_b4 <= r_prod >> 15;
            S_P7: begin
                r_rem  <= 33'd0;
                r_cnt  <= 5'd0;
                r_quo  <= b7[31] ? b7 : {b7[30:0], 1'b0};
                r_dvs  <= r_b4;
                r_qneg <= 1'b0;
                r_qshl <= b7[31];
                if (r_b4 == 32'd0) begin
                    r_err   <= 1'b1;
                    r_value <= 32'd0;
                end
            end
            S_DIV: begin
                r_cnt <= r_cnt + 5'd1;
                if (shifted >= {1'b0, r_dvs}) begin
                    r_rem <= shifted - {1'b0, r_dvs};
                    r_quo <= {r_quo[30:0], 1'b1};
                end else begin
                    r_rem <= shifted;
                    r_quo <= {r_quo[30:0], 1'b0};
                end
            end
            S_Q0: r_pv <= q_fin;
            S_Q2: r_x1 <= 32'($signed(r_prod) >>> 16);
            S_Q3: r_value <= r_pv + 32'($signed(pq) >>> 4);
            default: r_cnt <= r_cnt;
        endcase
    end

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.div_error) |-> (o_res.result_value == 32'd0))
        else $error("error result carries nonzero value");

    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> (r_state == S_T0 || r_state == S_P0))
        else $error("request did not start a sequence");

    a_div_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && !div_done) |=> (r_state == S_DIV))
        else $error("divider left early");

endmodule
